// ===== hw/rtl/dtpg_pkg.sv =====
// Shared types, constants and colour tables of the display test pattern generator.
// Depends on nothing; every other file of the block imports it.

package dtpg_pkg;

   // Frame geometry
   localparam int FRAME_WIDTH  = 1280;
   localparam int FRAME_HEIGHT = 720;

   // Field widths
   localparam int X_W    = 11;
   localparam int Y_W    = 10;
   localparam int DT_W   = 20;
   localparam int COL_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Width for comparisons against geometry thresholds (up to 8191)
   localparam int CMP_W = 13;

   // Ramp: v = cx * 255 / (FRAME_WIDTH - 1), by reciprocal plus one correction
   localparam int RAMP_DIV    = FRAME_WIDTH - 1;
   localparam int RECIP_SHIFT = 20;
   localparam int RAMP_RECIP  = (1 << RECIP_SHIFT) / RAMP_DIV;
   localparam int PROD_W      = 19;
   localparam int RECIP_W     = 17;

   localparam int BAND_H = FRAME_HEIGHT / 4;
   localparam int BAR_W  = FRAME_WIDTH / 8;
   localparam int STEP_W = FRAME_WIDTH / 16;

   // Strobe timing
   localparam int ACC_W     = 21;
   localparam int REM_W     = 19;
   localparam int DIV_STEPS = ACC_W;
   localparam int CNT_W     = 5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE    = 2'd2;

   // Pattern codes
   localparam logic [2:0] PAT_SOLID    = 3'd0;
   localparam logic [2:0] PAT_RAMPS    = 3'd1;
   localparam logic [2:0] PAT_GEOMETRY = 3'd2;
   localparam logic [2:0] PAT_BARS     = 3'd3;
   localparam logic [2:0] PAT_CHECKER  = 3'd4;
   localparam logic [2:0] PAT_STEPS    = 3'd5;
   localparam logic [2:0] PAT_STROBE   = 3'd6;

   // Input modes
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [2:0] RESET_PATTERN = PAT_SOLID;
   localparam logic [3:0] RESET_COLOUR  = 4'd0;
   localparam logic [4:0] RESET_RATE    = 5'd10;

   typedef struct packed {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
   } rgb_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PIX,
      ST_DIV
   } ctrl_state_type;

   typedef struct packed {
      logic load_pix;
      logic start_div;
      logic div_step;
      logic load_rsp;
   } dtpg_cmd_type;

   typedef struct packed {
      logic strobe_sel;
      logic div_last;
   } dtpg_status_type;

   function automatic rgb_type solid_colour(input logic [3:0] idx);
      rgb_type c;
      case (idx) inside
         4'd0:    c = '{8'd255, 8'd0,   8'd0};
         4'd1:    c = '{8'd0,   8'd255, 8'd0};
         4'd2:    c = '{8'd0,   8'd0,   8'd255};
         4'd3:    c = '{8'd255, 8'd255, 8'd255};
         4'd4:    c = '{8'd0,   8'd0,   8'd0};
         4'd5:    c = '{8'd128, 8'd128, 8'd128};
         4'd6:    c = '{8'd0,   8'd255, 8'd255};
         4'd7:    c = '{8'd255, 8'd0,   8'd255};
         [4'd8:4'd15]: c = '{8'd255, 8'd255, 8'd0};
         default: c = '{8'd255, 8'd255, 8'd0};
      endcase
      return c;
   endfunction

   function automatic rgb_type bar_colour(input logic [2:0] idx);
      rgb_type c;
      case (idx)
         3'd0:    c = '{8'd255, 8'd255, 8'd255};
         3'd1:    c = '{8'd255, 8'd255, 8'd0};
         3'd2:    c = '{8'd0,   8'd255, 8'd255};
         3'd3:    c = '{8'd0,   8'd255, 8'd0};
         3'd4:    c = '{8'd255, 8'd0,   8'd255};
         3'd5:    c = '{8'd255, 8'd0,   8'd0};
         3'd6:    c = '{8'd0,   8'd0,   8'd255};
         default: c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

   // Half strobe period in microseconds, floor(500000 / rate), rate clamped to 1..30
   function automatic logic [REM_W-1:0] half_period(input logic [4:0] rate);
      logic [REM_W-1:0] h;
      case (rate) inside
         5'd0, 5'd1: h = 19'd500000;
         5'd2:  h = 19'd250000;
         5'd3:  h = 19'd166666;
         5'd4:  h = 19'd125000;
         5'd5:  h = 19'd100000;
         5'd6:  h = 19'd83333;
         5'd7:  h = 19'd71428;
         5'd8:  h = 19'd62500;
         5'd9:  h = 19'd55555;
         5'd10: h = 19'd50000;
         5'd11: h = 19'd45454;
         5'd12: h = 19'd41666;
         5'd13: h = 19'd38461;
         5'd14: h = 19'd35714;
         5'd15: h = 19'd33333;
         5'd16: h = 19'd31250;
         5'd17: h = 19'd29411;
         5'd18: h = 19'd27777;
         5'd19: h = 19'd26315;
         5'd20: h = 19'd25000;
         5'd21: h = 19'd23809;
         5'd22: h = 19'd22727;
         5'd23: h = 19'd21739;
         5'd24: h = 19'd20833;
         5'd25: h = 19'd20000;
         5'd26: h = 19'd19230;
         5'd27: h = 19'd18518;
         5'd28: h = 19'd17857;
         5'd29: h = 19'd17241;
         default: h = 19'd16666;
      endcase
      return h;
   endfunction

endpackage

// ===== hw/rtl/dtpg_ctrl.sv =====
// Controller of the test pattern generator: handshakes, sequencing, result flag.
// Depends on dtpg_pkg.

module dtpg_ctrl import dtpg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_mode,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  dtpg_status_type status,
   output dtpg_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_PIX) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_PIX: begin
            if (state_ff == ST_PIX && !out_free) begin
               state_in = ST_PIX;
            end else if (accept && req_mode == MODE_PIXEL) begin
               state_in = ST_PIX;
            end else if (accept && status.strobe_sel) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd           = '0;
      cmd.load_pix  = accept && (req_mode == MODE_PIXEL);
      cmd.start_div = accept && (req_mode == MODE_TICK) && status.strobe_sel;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.load_rsp  = (state_ff == ST_PIX) && out_free;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/dtpg_datapath.sv =====
// Datapath of the test pattern generator: configuration, pattern colour,
// ramp divide, strobe divider and result registers. Depends on dtpg_pkg.

module dtpg_datapath import dtpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [X_W-1:0]        req_pixel_x,
   input  logic [Y_W-1:0]        req_pixel_y,
   input  logic [DT_W-1:0]       req_elapsed_us,
   input  dtpg_cmd_type          cmd,
   output dtpg_status_type       status,
   output logic [COL_W-1:0]      rsp_red,
   output logic [COL_W-1:0]      rsp_green,
   output logic [COL_W-1:0]      rsp_blue
);

   // Configuration
   logic [2:0] pattern_ff;
   logic [3:0] colour_ff;
   logic [4:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= RESET_PATTERN;
         colour_ff  <= RESET_COLOUR;
         rate_ff    <= RESET_RATE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN: pattern_ff <= csr_data[2:0];
            CSR_COLOUR:  colour_ff  <= csr_data[3:0];
            CSR_RATE:    rate_ff    <= csr_data;
            default:     ;
         endcase
      end
   end

   assign status.strobe_sel = (pattern_ff == PAT_STROBE);

   // Strobe phase, read by the pixel stage and advanced by the divider
   logic             white_ff, white_in;

   // Pixel stage one: clamp column, scale by 255, estimate the quotient
   logic [X_W-1:0]     x_ff, cx;
   logic [Y_W-1:0]     y_ff;
   logic [PROD_W-1:0]  p_ff, p_in;
   logic [COL_W-1:0]   q0_ff, q0_in;
   logic [PROD_W+RECIP_W-1:0] est;

   assign cx    = ({{(CMP_W-X_W){1'b0}}, req_pixel_x} > CMP_W'(RAMP_DIV))
                  ? X_W'(RAMP_DIV) : req_pixel_x;
   assign p_in  = {cx, 8'd0} - {8'd0, cx};
   assign est   = (PROD_W+RECIP_W)'(p_in) * (PROD_W+RECIP_W)'(RAMP_RECIP);
   assign q0_in = COL_W'(est >> RECIP_SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.load_pix) begin
         x_ff  <= req_pixel_x;
         y_ff  <= req_pixel_y;
         p_ff  <= p_in;
         q0_ff <= q0_in;
      end
   end

   // Pixel stage two: correct the ramp quotient and pick the colour
   logic [PROD_W:0]   qd, rem;
   logic [COL_W-1:0]  ramp_v;
   logic [CMP_W-1:0]  xc, yc;
   logic [2:0]        bar_idx;
   logic [3:0]        step_idx;
   logic [COL_W-1:0]  step_v;
   rgb_type           pix;

   assign qd     = (PROD_W+1)'(q0_ff) * (PROD_W+1)'(RAMP_DIV);
   assign rem    = {1'b0, p_ff} - qd;
   assign ramp_v = (rem >= (PROD_W+1)'(RAMP_DIV)) ? q0_ff + 8'd1 : q0_ff;
   assign xc     = CMP_W'(x_ff);
   assign yc     = CMP_W'(y_ff);

   always_comb begin
      bar_idx  = 3'd0;
      step_idx = 4'd0;
      for (int k = 1; k < 8; k++) begin
         if (xc >= CMP_W'(k * BAR_W)) bar_idx = 3'(k);
      end
      for (int k = 1; k < 16; k++) begin
         if (xc >= CMP_W'(k * STEP_W)) step_idx = 4'(k);
      end
   end

   assign step_v = {step_idx, step_idx};  // i * 17

   always_comb begin
      pix = '0;
      case (pattern_ff)
         PAT_SOLID: pix = solid_colour(colour_ff);
         PAT_RAMPS: begin
            if (yc < CMP_W'(BAND_H)) begin
               pix = '{ramp_v, ramp_v, ramp_v};
            end else if (yc < CMP_W'(2 * BAND_H)) begin
               pix.red = ramp_v;
            end else if (yc < CMP_W'(3 * BAND_H)) begin
               pix.green = ramp_v;
            end else begin
               pix.blue = ramp_v;
            end
         end
         PAT_BARS:    pix = bar_colour(bar_idx);
         PAT_CHECKER: pix = (x_ff[0] ^ y_ff[0]) ? '1 : '0;
         PAT_STEPS:   pix = '{step_v, step_v, step_v};
         PAT_STROBE:  pix = white_ff ? '1 : '0;
         default:     pix = '0;
      endcase
   end

   rgb_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) rsp_ff <= pix;
   end

   assign rsp_red   = rsp_ff.red;
   assign rsp_green = rsp_ff.green;
   assign rsp_blue  = rsp_ff.blue;

   // Strobe: restoring divide of (accumulator + elapsed) by the half period
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] dvd_ff;
   logic [REM_W-1:0] rem_ff, rem_next, half_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [REM_W:0]   trial;
   logic             qbit;

   assign trial    = {rem_ff, dvd_ff[ACC_W-1]};
   assign qbit     = trial >= {1'b0, half_ff};
   assign rem_next = qbit ? REM_W'(trial - {1'b0, half_ff}) : REM_W'(trial);
   assign status.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      acc_in   = acc_ff;
      white_in = white_ff;
      if (cmd.div_step && status.div_last) begin
         acc_in   = ACC_W'(rem_next);
         white_in = white_ff ^ qbit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         white_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         white_ff <= white_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start_div) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         dvd_ff  <= acc_ff + ACC_W'(req_elapsed_us);
         rem_ff  <= '0;
         half_ff <= half_period(rate_ff);
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[ACC_W-2:0], 1'b0};
         rem_ff  <= rem_next;
      end
   end

endmodule

// ===== hw/rtl/display_test_pattern_generator_unit.sv =====
// Top level of the display test pattern generator: controller plus datapath.
// Depends on dtpg_pkg, dtpg_ctrl and dtpg_datapath.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_mode, req_pixel_x, req_pixel_y, req_elapsed_us
//   rsp       out        rsp_valid/rsp_ready  rsp_red, rsp_green, rsp_blue
//   csr       in         csr_we (no wait)     csr_index, csr_data
//
// A pixel beat has its ramp quotient estimated by a reciprocal multiply at
// accept and corrected in the following cycle, which also loads the result
// register once the output is free, so pixels stream at one per clock while
// rsp_ready keeps up. A tick beat with the strobe selected occupies the block
// until the restoring divider is done (one quotient bit a cycle) and takes no
// new beat meanwhile; other ticks give no result.
// Reset is synchronous and active high: registers return to pattern 0, colour
// index 0, rate 10 Hz, accumulator zero, strobe black.
// A stalled result holds in the output register; one more pixel can sit in the
// first stage behind it, after which req_ready drops.

module display_test_pattern_generator_unit import dtpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [X_W-1:0]        req_pixel_x,
   input  logic [Y_W-1:0]        req_pixel_y,
   input  logic [DT_W-1:0]       req_elapsed_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COL_W-1:0]      rsp_red,
   output logic [COL_W-1:0]      rsp_green,
   output logic [COL_W-1:0]      rsp_blue,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dtpg_cmd_type    cmd;
   dtpg_status_type status;

   // Sequencing and handshakes
   dtpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, colour logic and strobe divider
   dtpg_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_elapsed_us (req_elapsed_us),
      .cmd            (cmd),
      .status         (status),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // Never accept a beat while the divider runs
   assert property (@(posedge clock) disable iff (reset) cmd.div_step |-> !req_ready)
      else $error("beat accepted during strobe divide");

   // Never overwrite a result that has not been taken
   assert property (@(posedge clock) disable iff (reset)
                    cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // A started divide steps in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.start_div |=> cmd.div_step)
      else $error("divide did not start");

   // A divide start only comes with a tick beat under the strobe pattern
   assert property (@(posedge clock) disable iff (reset)
                    cmd.start_div |-> (req_valid && req_ready && req_mode == MODE_TICK))
      else $error("divide started without a tick");

endmodule
